// ===== rtl/prtt_pkg.sv =====
// shared types and constants of the pending request table
package prtt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam logic [15:0] EXPIRE_AGE_RESET = 16'd120;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_MARK,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_SQUEEZE,
    ST_RESULT
  } state_e;

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_FETCH = 1'b1
  } action_e;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  kind;
    logic [15:0] tag;
    logic [31:0] stamp;
  } payload_t;

  typedef struct packed {
    logic     occ;
    logic     kill;
    payload_t data;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    payload_t    item;
    logic [15:0] age;
  } bus_t;

  typedef struct packed {
    cell_op_e op;
    logic     sel;
  } cell_ctrl_t;

  typedef struct packed {
    logic kind_hit;
    logic id_hit;
    logic free;
    logic kill;
    logic [15:0] tag;
  } cell_stat_t;

endpackage

// ===== rtl/pending_request_table_with_timeout_top.sv =====
// top level: controller, chain of table cells, result register and config register
// sequence: an add passes through the mark and result states; a fetch passes through mark,
//   squeeze until every removed entry (expired ones plus the matched one, up to 16) is gone,
//   and result; the squeeze compacts one slot per cycle through the cell chain
// one transaction at a time: requests are taken only when idle; result waits for the output
// reset: table empty, expire age 120, no result pending
module pending_request_table_with_timeout_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,  // request_id, proc_kind, handler_tag, now
  input  logic         s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,  // found_tag
  output logic [1:0]   m_axis_tuser,  // hit, dropped
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  localparam int unsigned D = prtt_pkg::TABLE_DEPTH;

  prtt_pkg::state_e     state_q, state_d;
  logic [15:0]          age_q;
  logic                 action_q;
  prtt_pkg::payload_t   item_q;
  prtt_pkg::bus_t       bus;
  prtt_pkg::cell_ctrl_t ctrl  [D];
  prtt_pkg::entry_t     ent   [D+1];
  prtt_pkg::cell_stat_t stat  [D];

  logic [D-1:0] kind_vec, id_vec, free_vec, kill_vec, kind_sel, id_sel, free_sel, shift_vec;
  logic         kind_any, id_any, free_any, kill_any;
  logic [15:0]  sel_tag;
  logic         res_hit_q, res_drop_q;
  logic [15:0]  res_tag_q;
  logic         out_valid_q;
  logic         out_hit_q, out_drop_q;
  logic [15:0]  out_tag_q;
  logic         in_fire, out_load;

  function automatic logic [D-1:0] first_one(input logic [D-1:0] v);
    logic [D-1:0] r;
    logic         seen;
    r    = '0;
    seen = 1'b0;
    for (int k = 0; k < D; k++) begin
      r[k] = v[k] && !seen;
      seen = seen || v[k];
    end
    return r;
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == prtt_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == prtt_pkg::ST_RESULT) && (!out_valid_q || m_axis_tready);

  assign bus.item = item_q;
  assign bus.age  = age_q;

  assign ent[D] = '0;

  for (genvar g = 0; g < D; g++) begin : g_cell
    prtt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[g]),
      .bus_i  (bus),
      .nbr_i  (ent[g+1]),
      .ent_o  (ent[g]),
      .stat_o (stat[g])
    );
    assign kind_vec[g] = stat[g].kind_hit;
    assign id_vec[g]   = stat[g].id_hit;
    assign free_vec[g] = stat[g].free;
    assign kill_vec[g] = stat[g].kill;
  end

  assign kind_sel = first_one(kind_vec);
  assign id_sel   = first_one(id_vec);
  assign free_sel = first_one(free_vec);
  assign kind_any = (|kind_vec) && (item_q.kind != 8'd0);
  assign id_any   = |id_vec;
  assign free_any = |free_vec;
  assign kill_any = |kill_vec;

  always_comb begin
    logic run;
    run       = 1'b0;
    shift_vec = '0;
    sel_tag   = '0;
    for (int k = 0; k < D; k++) begin
      run          = run || kill_vec[k];
      shift_vec[k] = run;
      sel_tag      = sel_tag | (id_sel[k] ? stat[k].tag : 16'd0);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      prtt_pkg::ST_IDLE: begin
        if (in_fire) state_d = prtt_pkg::ST_MARK;
      end
      prtt_pkg::ST_MARK: begin
        state_d = (action_q == prtt_pkg::ACT_FETCH) ? prtt_pkg::ST_SQUEEZE
                                                    : prtt_pkg::ST_RESULT;
      end
      prtt_pkg::ST_SQUEEZE: begin
        if (!kill_any) state_d = prtt_pkg::ST_RESULT;
      end
      prtt_pkg::ST_RESULT: begin
        if (out_load) state_d = prtt_pkg::ST_IDLE;
      end
      default: state_d = prtt_pkg::ST_IDLE;
    endcase
  end

  // cell controls
  always_comb begin
    for (int k = 0; k < D; k++) begin
      ctrl[k].op  = prtt_pkg::CELL_HOLD;
      ctrl[k].sel = 1'b0;
    end
    case (state_q)
      prtt_pkg::ST_MARK: begin
        for (int k = 0; k < D; k++) begin
          if (action_q == prtt_pkg::ACT_FETCH) begin
            ctrl[k].op  = prtt_pkg::CELL_MARK;
            ctrl[k].sel = id_sel[k];
          end else if (kind_any ? kind_sel[k] : free_sel[k]) begin
            ctrl[k].op = prtt_pkg::CELL_WRITE;
          end
        end
      end
      prtt_pkg::ST_SQUEEZE: begin
        for (int k = 0; k < D; k++) begin
          if (shift_vec[k]) ctrl[k].op = prtt_pkg::CELL_SHIFT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prtt_pkg::ST_IDLE;
      age_q       <= prtt_pkg::EXPIRE_AGE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) age_q <= cfg_data_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q     <= s_axis_tuser;
      item_q.id    <= s_axis_tdata[31:0];
      item_q.kind  <= s_axis_tdata[39:32];
      item_q.tag   <= s_axis_tdata[55:40];
      item_q.stamp <= s_axis_tdata[87:56];
    end
    if (state_q == prtt_pkg::ST_MARK) begin
      if (action_q == prtt_pkg::ACT_FETCH) begin
        res_hit_q  <= id_any;
        res_tag_q  <= sel_tag;
        res_drop_q <= 1'b0;
      end else begin
        res_hit_q  <= 1'b0;
        res_tag_q  <= 16'd0;
        res_drop_q <= !kind_any && !free_any;
      end
    end
    if (out_load) begin
      out_hit_q  <= res_hit_q;
      out_tag_q  <= res_tag_q;
      out_drop_q <= res_drop_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tag_q;
  assign m_axis_tuser  = {out_drop_q, out_hit_q};

  logic [D-1:0] occ_vec;
  for (genvar g = 0; g < D; g++) begin : g_occ
    assign occ_vec[g] = ent[g].occ;
  end

  a_occ_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((occ_vec + 1'b1) & occ_vec) == '0) || (state_q == prtt_pkg::ST_SQUEEZE))
    else $error("occupied cells not contiguous from the head");

  a_hit_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result flags both hit and dropped");

  a_miss_tag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
    else $error("tag nonzero without a hit");

  a_drop_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prtt_pkg::ST_MARK && action_q == prtt_pkg::ACT_ADD && free_any)
      |=> !res_drop_q)
    else $error("add dropped with a free cell");

endmodule

// ===== rtl/prtt_cell.sv =====
// one table slot: holds an entry, compares it, and shifts from its right neighbor
module prtt_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prtt_pkg::cell_ctrl_t  ctrl_i,
  input  prtt_pkg::bus_t        bus_i,
  input  prtt_pkg::entry_t      nbr_i,
  output prtt_pkg::entry_t      ent_o,
  output prtt_pkg::cell_stat_t  stat_o
);

  logic               occ_q, occ_d;
  logic               kill_q, kill_d;
  prtt_pkg::payload_t data_q, data_d;
  logic               expired;
  logic [32:0]        limit;

  assign limit   = {1'b0, data_q.stamp} + {17'b0, bus_i.age};
  assign expired = occ_q && (limit < {1'b0, bus_i.item.stamp});

  always_comb begin
    occ_d  = occ_q;
    kill_d = kill_q;
    data_d = data_q;
    case (ctrl_i.op)
      prtt_pkg::CELL_WRITE: begin
        occ_d  = 1'b1;
        kill_d = 1'b0;
        data_d = bus_i.item;
      end
      prtt_pkg::CELL_MARK: begin
        kill_d = expired || ctrl_i.sel;
      end
      prtt_pkg::CELL_SHIFT: begin
        occ_d  = nbr_i.occ;
        kill_d = nbr_i.kill;
        data_d = nbr_i.data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      kill_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      kill_q <= kill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign ent_o.occ  = occ_q;
  assign ent_o.kill = kill_q;
  assign ent_o.data = data_q;

  assign stat_o.kind_hit = occ_q && (data_q.kind == bus_i.item.kind);
  assign stat_o.id_hit   = occ_q && !expired && (data_q.id == bus_i.item.id);
  assign stat_o.free     = !occ_q;
  assign stat_o.kill     = kill_q;
  assign stat_o.tag      = data_q.tag;

endmodule
